// File: rtl/core/brn_pkg.sv
// ----------------------------------------------------------------------------
// brn_pkg: shared types and constants of the bilinear resize and normalize block
// Payload structures, command codes, register indexes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package brn_pkg;

    // Clamped frame dimensions go up to 4096, coordinates up to 4095.
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned STEP_W   = DIM_W + FRAC_W;
    localparam int unsigned WGT_W    = FRAC_W + 1;
    localparam int unsigned CALC_W   = 25;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_RGB   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STDDEV_RGB = 3'd6;

    localparam logic [CFG_DATA_W-1:0] STDDEV_RESET = 48'h1000_1000_1000;
    localparam logic [15:0]           SD_ONE       = 16'd4096;

    // Command codes travelling from the front end to the back end.
    localparam int unsigned OP_W = 2;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_ERROR = 2'd2;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = 1;
    localparam int unsigned FIFO_CNT_W = 2;

    typedef struct packed {
        logic       req_type;
        logic [9:0] pix_x;
        logic [9:0] pix_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_red;
        logic signed [15:0] out_green;
        logic signed [15:0] out_blue;
        logic               out_error;
    } out_item_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fy;
        logic [23:0]        rgb;
    } cmd_t;

    typedef struct packed {
        logic        norm_enable;
        logic [47:0] mean_rgb;
        logic [47:0] stddev_rgb;
    } norm_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/brn_if.sv
// ----------------------------------------------------------------------------
// brn_if: handshake channels of the bilinear resize and normalize block
// Pixel request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface brn_in_if;
    import brn_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brn_out_if;
    import brn_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brn_cfg_if;
    import brn_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bilinear_resize_normalize.sv
// ----------------------------------------------------------------------------
// bilinear_resize_normalize: bilinear image scaler with channel normalization
// Stores RGB source pixels and answers destination pixel requests with
// interpolated, optionally normalized, signed Q4.12 samples.
// ----------------------------------------------------------------------------
`default_nettype none

// A write request stores one RGB pixel and gives no result; a read request
// gives exactly one result, in request order. The front end takes a new
// request only once the previous one has left it, and hands a decoded command
// to a two-entry queue. The back end owns the single-port frame store: a write
// command is a single store write there, a read runs four store reads,
// accumulation, the 1/255 scaling and the result register, and, when
// normalization is on, one division per channel, since the three channels share
// one serial divider that produces one quotient bit per cycle. After every
// configuration write the front end recomputes the scale steps with its own
// serial divider and takes no request meanwhile. The frame store is not cleared;
// reading a pixel that was never written returns undefined data.

module bilinear_resize_normalize #(
    parameter int unsigned MAX_SRC_WIDTH  = 256,
    parameter int unsigned MAX_SRC_HEIGHT = 256,
    parameter int unsigned MAX_DST_DIM    = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    brn_cfg_if.sink   cfg,
    brn_in_if.sink    pix_in,
    brn_out_if.source pix_out
);
    import brn_pkg::*;

    // Decoded commands flow from the front end through the queue.
    logic      push;
    cmd_t      push_cmd;
    logic      full;
    logic      pop;
    cmd_t      pop_cmd;
    logic      empty;
    norm_cfg_t norm_cfg;

    brn_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_DIM    (MAX_DST_DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pix_in   (pix_in),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .norm_cfg (norm_cfg)
    );

    // The queue lets the front end keep accepting while the back end works.
    brn_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    brn_back #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_cmd  (pop_cmd),
        .empty    (empty),
        .pop      (pop),
        .norm_cfg (norm_cfg),
        .pix_out  (pix_out)
    );

endmodule

`default_nettype wire

// File: rtl/core/brn_fifo.sv
// ----------------------------------------------------------------------------
// brn_fifo: command queue between front end and back end
// A two-entry queue of decoded commands.
// ----------------------------------------------------------------------------
`default_nettype none

module brn_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire brn_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output brn_pkg::cmd_t      pop_cmd,
    output logic               empty
);
    import brn_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/brn_front.sv
// ----------------------------------------------------------------------------
// brn_front: request front end
// Holds the configuration, derives the scale steps with a serial divider,
// maps requests to source coordinates and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module brn_front #(
    parameter int unsigned MAX_SRC_WIDTH  = 256,
    parameter int unsigned MAX_SRC_HEIGHT = 256,
    parameter int unsigned MAX_DST_DIM    = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    brn_cfg_if.sink            cfg,
    brn_in_if.sink             pix_in,
    output logic               push,
    output brn_pkg::cmd_t      push_cmd,
    input  wire logic          full,
    output brn_pkg::norm_cfg_t norm_cfg
);
    import brn_pkg::*;

    localparam logic F_IDLE = 1'b0;
    localparam logic F_PUSH = 1'b1;
    localparam int unsigned DIV_CNT_W = $clog2(STEP_W + 1);
    localparam int unsigned POS_W     = 10 + STEP_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [10:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = DIM_W'(v);
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (DIM_W'(v) > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    logic [8:0]            src_width_reg;
    logic [8:0]            src_height_reg;
    logic [10:0]           dst_width_reg;
    logic [10:0]           dst_height_reg;
    logic                  norm_enable_reg;
    logic [47:0]           mean_rgb_reg;
    logic [47:0]           stddev_rgb_reg;

    logic [DIM_W-1:0]      sw_eff;
    logic [DIM_W-1:0]      sh_eff;
    logic [DIM_W-1:0]      dw_eff;
    logic [DIM_W-1:0]      dh_eff;

    // The step registers double as dividend and quotient shift registers.
    logic [STEP_W-1:0]     step_x_reg;
    logic [STEP_W-1:0]     step_y_reg;
    logic [DIM_W-1:0]      rem_x_reg;
    logic [DIM_W-1:0]      rem_y_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic                  div_start_reg;
    logic                  div_busy;
    logic [DIM_W:0]        rem_x_sh;
    logic [DIM_W:0]        rem_y_sh;
    logic                  ge_x;
    logic                  ge_y;

    logic                  st_reg;
    logic                  st_next;
    in_item_t              item_reg;
    logic [POS_W-1:0]      posx_reg;
    logic [POS_W-1:0]      posy_reg;

    logic [DIM_W-1:0]      sw_m1;
    logic [DIM_W-1:0]      sh_m1;
    logic [POS_W-17:0]     x0_raw;
    logic [POS_W-17:0]     y0_raw;
    logic [COORD_W-1:0]    x0c;
    logic [COORD_W-1:0]    y0c;
    logic [COORD_W-1:0]    x1c;
    logic [COORD_W-1:0]    y1c;
    logic                  out_of_frame;
    logic                  in_store;
    logic                  needs_push;

    assign cfg.ready = 1'b1;

    assign sw_eff = clamp_dim({2'b00, src_width_reg},  DIM_W'(MAX_SRC_WIDTH));
    assign sh_eff = clamp_dim({2'b00, src_height_reg}, DIM_W'(MAX_SRC_HEIGHT));
    assign dw_eff = clamp_dim(dst_width_reg,  DIM_W'(MAX_DST_DIM));
    assign dh_eff = clamp_dim(dst_height_reg, DIM_W'(MAX_DST_DIM));

    assign norm_cfg.norm_enable = norm_enable_reg;
    assign norm_cfg.mean_rgb    = mean_rgb_reg;
    assign norm_cfg.stddev_rgb  = stddev_rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= 9'd1;
            src_height_reg  <= 9'd1;
            dst_width_reg   <= 11'd1;
            dst_height_reg  <= 11'd1;
            norm_enable_reg <= 1'b0;
            mean_rgb_reg    <= '0;
            stddev_rgb_reg  <= STDDEV_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SRC_WIDTH:  src_width_reg   <= cfg.data[8:0];
                REG_SRC_HEIGHT: src_height_reg  <= cfg.data[8:0];
                REG_DST_WIDTH:  dst_width_reg   <= cfg.data[10:0];
                REG_DST_HEIGHT: dst_height_reg  <= cfg.data[10:0];
                REG_NORM_EN:    norm_enable_reg <= cfg.data[0];
                REG_MEAN_RGB:   mean_rgb_reg    <= cfg.data;
                REG_STDDEV_RGB: stddev_rgb_reg  <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Restoring division, one quotient bit per cycle, after every register write.
    assign div_busy = div_start_reg || (div_cnt_reg != '0);
    assign rem_x_sh = {rem_x_reg, step_x_reg[STEP_W-1]};
    assign rem_y_sh = {rem_y_reg, step_y_reg[STEP_W-1]};
    assign ge_x     = (rem_x_sh >= {1'b0, dw_eff});
    assign ge_y     = (rem_y_sh >= {1'b0, dh_eff});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_reg <= 1'b0;
            div_cnt_reg   <= '0;
            step_x_reg    <= STEP_RESET;
            step_y_reg    <= STEP_RESET;
            rem_x_reg     <= '0;
            rem_y_reg     <= '0;
        end
        else
        begin
            div_start_reg <= cfg.valid;
            if (div_start_reg)
            begin
                step_x_reg  <= {sw_eff, {FRAC_W{1'b0}}};
                step_y_reg  <= {sh_eff, {FRAC_W{1'b0}}};
                rem_x_reg   <= '0;
                rem_y_reg   <= '0;
                div_cnt_reg <= DIV_CNT_W'(STEP_W);
            end
            else if (div_cnt_reg != '0)
            begin
                step_x_reg  <= {step_x_reg[STEP_W-2:0], ge_x};
                step_y_reg  <= {step_y_reg[STEP_W-2:0], ge_y};
                rem_x_reg   <= ge_x ? DIM_W'(rem_x_sh - {1'b0, dw_eff})
                                    : DIM_W'(rem_x_sh);
                rem_y_reg   <= ge_y ? DIM_W'(rem_y_sh - {1'b0, dh_eff})
                                    : DIM_W'(rem_y_sh);
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end
    end

    // Request capture: the position products are registered at acceptance.
    assign pix_in.ready = (st_reg == F_IDLE) && !div_busy;

    always_ff @(posedge clk)
    begin
        if (pix_in.valid && pix_in.ready)
        begin
            item_reg <= pix_in.data;
            posx_reg <= POS_W'(pix_in.data.pix_x) * POS_W'(step_x_reg);
            posy_reg <= POS_W'(pix_in.data.pix_y) * POS_W'(step_y_reg);
        end
    end

    // Classification and edge clamping.
    assign sw_m1  = sw_eff - 1'b1;
    assign sh_m1  = sh_eff - 1'b1;
    assign x0_raw = posx_reg[POS_W-1:16];
    assign y0_raw = posy_reg[POS_W-1:16];
    assign x0c    = (x0_raw > (POS_W-16)'(sw_m1)) ? sw_m1[COORD_W-1:0]
                                                  : x0_raw[COORD_W-1:0];
    assign y0c    = (y0_raw > (POS_W-16)'(sh_m1)) ? sh_m1[COORD_W-1:0]
                                                  : y0_raw[COORD_W-1:0];
    assign x1c    = (({1'b0, x0c} + 1'b1) < sw_eff) ? (x0c + 1'b1) : sw_m1[COORD_W-1:0];
    assign y1c    = (({1'b0, y0c} + 1'b1) < sh_eff) ? (y0c + 1'b1) : sh_m1[COORD_W-1:0];

    assign out_of_frame = (DIM_W'(item_reg.pix_x) >= dw_eff) ||
                          (DIM_W'(item_reg.pix_y) >= dh_eff);
    assign in_store     = (32'(item_reg.pix_x) < MAX_SRC_WIDTH) &&
                          (32'(item_reg.pix_y) < MAX_SRC_HEIGHT);
    assign needs_push   = item_reg.req_type || in_store;

    always_comb
    begin
        push_cmd     = '0;
        push_cmd.fx  = posx_reg[FRAC_W-1:0];
        push_cmd.fy  = posy_reg[FRAC_W-1:0];
        push_cmd.rgb = {item_reg.blue, item_reg.green, item_reg.red};
        if (!item_reg.req_type)
        begin
            push_cmd.op = OP_WRITE;
            push_cmd.x0 = COORD_W'(item_reg.pix_x);
            push_cmd.y0 = COORD_W'(item_reg.pix_y);
        end
        else if (out_of_frame)
        begin
            push_cmd.op = OP_ERROR;
        end
        else
        begin
            push_cmd.op = OP_READ;
            push_cmd.x0 = x0c;
            push_cmd.x1 = x1c;
            push_cmd.y0 = y0c;
            push_cmd.y1 = y1c;
        end
    end

    assign push = (st_reg == F_PUSH) && needs_push && !full;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE:
            begin
                if (pix_in.valid && pix_in.ready)
                begin
                    st_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!needs_push || !full)
                begin
                    st_next = F_IDLE;
                end
            end
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= F_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/brn_back.sv
// ----------------------------------------------------------------------------
// brn_back: command back end
// Owns the frame store, interpolates four samples, scales by 1/255 and
// optionally normalizes each channel with a shared serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module brn_back #(
    parameter int unsigned MAX_SRC_WIDTH  = 256,
    parameter int unsigned MAX_SRC_HEIGHT = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire brn_pkg::cmd_t      pop_cmd,
    input  wire logic               empty,
    output logic                    pop,
    input  wire brn_pkg::norm_cfg_t norm_cfg,
    brn_out_if.source               pix_out
);
    import brn_pkg::*;

    localparam int unsigned DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned W_W    = 2 * FRAC_W + 1;
    localparam int unsigned ACC_W  = 40;
    localparam int unsigned U_W    = 21;
    localparam int unsigned RCP_W  = 17;
    localparam int unsigned PRD_W  = U_W + RCP_W;
    localparam int unsigned Q_W    = 14;
    localparam int unsigned DVD_W  = 29;
    localparam int unsigned DCNT_W = $clog2(DVD_W + 1);

    localparam logic [RCP_W-1:0] RECIP_255 = 17'd65793;
    localparam logic [ACC_W:0]   HALF_LSB  = (ACC_W+1)'(255) << 19;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_RD   = 4'd1;
    localparam logic [3:0] B_ACC  = 4'd2;
    localparam logic [3:0] B_SC1  = 4'd3;
    localparam logic [3:0] B_SC2  = 4'd4;
    localparam logic [3:0] B_NSET = 4'd5;
    localparam logic [3:0] B_DIV  = 4'd6;
    localparam logic [3:0] B_NFIN = 4'd7;
    localparam logic [3:0] B_EMIT = 4'd8;

    logic [23:0]          mem [DEPTH];
    logic [23:0]          rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_addr;
    logic [COORD_W-1:0]   ax;
    logic [COORD_W-1:0]   ay;
    logic [CALC_W-1:0]    addr_full;

    logic [3:0]           st_reg;
    logic [3:0]           st_next;
    cmd_t                 cmd_reg;
    logic [1:0]           rd_cnt_reg;
    logic                 rd_pend_reg;
    logic [W_W-1:0]       w_reg;
    logic [WGT_W-1:0]     gx;
    logic [WGT_W-1:0]     gy;
    logic [WGT_W-1:0]     wx;
    logic [WGT_W-1:0]     wy;
    logic [ACC_W-1:0]     acc_reg [3];
    logic [U_W-1:0]       u_reg [3];
    logic [PRD_W-1:0]     prod_reg [3];
    logic [15:0]          res_reg [3];
    logic                 err_reg;
    logic [1:0]           ch_reg;

    logic [DVD_W-1:0]     dvd_reg;
    logic [15:0]          rem_reg;
    logic [15:0]          dvs_reg;
    logic                 neg_reg;
    logic [DCNT_W-1:0]    dcnt_reg;
    logic [16:0]          rem_sh;
    logic                 ge;

    logic                 out_valid_reg;
    out_item_t            out_data_reg;
    logic                 emit;

    // Normalization set-up for the current channel.
    logic [12:0]          n_cur;
    logic signed [15:0]   mean_cur;
    logic [15:0]          sd_raw;
    logic [15:0]          sd_cur;
    logic signed [17:0]   d_cur;
    logic [16:0]          d_mag;

    // Quotient by 255 from a reciprocal estimate, corrected by one.
    function automatic logic [12:0] scale_fix(input logic [U_W-1:0] u,
                                              input logic [Q_W-1:0] q0);
        logic [U_W:0] q255;
        logic [U_W:0] r;
        logic [Q_W-1:0] q;
        q255 = {q0, 8'h00} - (U_W+1)'(q0);
        r    = (U_W+1)'(u) - q255;
        q    = (r >= (U_W+1)'(255)) ? (q0 + 1'b1) : q0;
        return q[12:0];
    endfunction

    assign pop = (st_reg == B_IDLE) && !empty;

    // Frame store address: y * MAX_SRC_WIDTH + x.
    always_comb
    begin
        ax = cmd_reg.x0;
        ay = cmd_reg.y0;
        if (st_reg == B_IDLE)
        begin
            ax = pop_cmd.x0;
            ay = pop_cmd.y0;
        end
        else
        begin
            if (rd_cnt_reg[0])
            begin
                ax = cmd_reg.x1;
            end
            if (rd_cnt_reg[1])
            begin
                ay = cmd_reg.y1;
            end
        end
    end

    assign addr_full = CALC_W'(ay) * CALC_W'(MAX_SRC_WIDTH) + CALC_W'(ax);
    assign mem_addr  = addr_full[AW-1:0];
    assign mem_we    = pop && (pop_cmd.op == OP_WRITE);
    assign mem_re    = (st_reg == B_RD);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= pop_cmd.rgb;
        end
        else if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Bilinear weights of the sample being read.
    assign gx = WGT_W'(17'h10000) - WGT_W'(cmd_reg.fx);
    assign gy = WGT_W'(17'h10000) - WGT_W'(cmd_reg.fy);
    assign wx = rd_cnt_reg[0] ? WGT_W'(cmd_reg.fx) : gx;
    assign wy = rd_cnt_reg[1] ? WGT_W'(cmd_reg.fy) : gy;

    // Serial divider step.
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    assign n_cur    = res_reg[ch_reg][12:0];
    assign mean_cur = $signed(norm_cfg.mean_rgb[16*ch_reg +: 16]);
    assign sd_raw   = norm_cfg.stddev_rgb[16*ch_reg +: 16];
    assign sd_cur   = (sd_raw == '0) ? SD_ONE : sd_raw;
    assign d_cur    = $signed({5'b00000, n_cur}) - 18'(mean_cur);
    assign d_mag    = d_cur[17] ? 17'(-d_cur) : d_cur[16:0];

    assign emit = (st_reg == B_EMIT) && (!out_valid_reg || pix_out.ready);

    always_ff @(posedge clk)
    begin
        w_reg <= W_W'(wx * wy);
        if (pop)
        begin
            cmd_reg <= pop_cmd;
            err_reg <= (pop_cmd.op == OP_ERROR);
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= '0;
                res_reg[c] <= '0;
            end
        end
        else if (rd_pend_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= acc_reg[c] + ACC_W'(rdata_reg[8*c +: 8] * w_reg);
            end
        end
        if (st_reg == B_SC1)
        begin
            for (int c = 0; c < 3; c++)
            begin
                u_reg[c]    <= U_W'(((ACC_W+1)'(acc_reg[c]) + HALF_LSB) >> 20);
                prod_reg[c] <= PRD_W'(U_W'(((ACC_W+1)'(acc_reg[c]) + HALF_LSB) >> 20))
                               * PRD_W'(RECIP_255);
            end
        end
        if (st_reg == B_SC2)
        begin
            for (int c = 0; c < 3; c++)
            begin
                res_reg[c] <= 16'(scale_fix(u_reg[c], prod_reg[c][PRD_W-1:24]));
            end
        end
        if (st_reg == B_NSET)
        begin
            dvd_reg  <= DVD_W'({d_mag, 12'h000}) + DVD_W'(sd_cur >> 1);
            dvs_reg  <= sd_cur;
            neg_reg  <= d_cur[17];
            rem_reg  <= '0;
            dcnt_reg <= DCNT_W'(DVD_W);
        end
        if (st_reg == B_DIV)
        begin
            dvd_reg  <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg  <= ge ? 16'(rem_sh - {1'b0, dvs_reg}) : rem_sh[15:0];
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (st_reg == B_NFIN)
        begin
            if (neg_reg)
            begin
                res_reg[ch_reg] <= (dvd_reg > DVD_W'(32768)) ? 16'h8000
                                                             : 16'(17'd0 - dvd_reg[16:0]);
            end
            else
            begin
                res_reg[ch_reg] <= (dvd_reg > DVD_W'(32767)) ? 16'h7FFF : dvd_reg[15:0];
            end
        end
        if (emit)
        begin
            out_data_reg.out_red   <= res_reg[0];
            out_data_reg.out_green <= res_reg[1];
            out_data_reg.out_blue  <= res_reg[2];
            out_data_reg.out_error <= err_reg;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    if (pop_cmd.op == OP_READ)
                    begin
                        st_next = B_RD;
                    end
                    else if (pop_cmd.op == OP_ERROR)
                    begin
                        st_next = B_EMIT;
                    end
                end
            end
            B_RD:
            begin
                if (rd_cnt_reg == 2'd3)
                begin
                    st_next = B_ACC;
                end
            end
            B_ACC:  st_next = B_SC1;
            B_SC1:  st_next = B_SC2;
            B_SC2:  st_next = norm_cfg.norm_enable ? B_NSET : B_EMIT;
            B_NSET: st_next = B_DIV;
            B_DIV:
            begin
                if (dcnt_reg == DCNT_W'(1))
                begin
                    st_next = B_NFIN;
                end
            end
            B_NFIN: st_next = (ch_reg == 2'd2) ? B_EMIT : B_NSET;
            B_EMIT:
            begin
                if (emit)
                begin
                    st_next = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            rd_pend_reg <= (st_reg == B_RD);
            if (st_reg == B_RD)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            else
            begin
                rd_cnt_reg <= '0;
            end
            if (st_reg == B_SC2)
            begin
                ch_reg <= '0;
            end
            else if (st_reg == B_NFIN)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_data_reg;

endmodule

`default_nettype wire
